[rtl/vbe_pkg.sv]
// ----------------------------------------------------------------------------
// VPIN volume bucket estimator package
// Widths, register indexes and the records passed between the blocks.
// ----------------------------------------------------------------------------
package vbe_pkg;

   localparam int PRICE_W       = 32;
   localparam int QTY_W         = 24;
   localparam int BUCKET_W      = 24;
   localparam int WIN_W         = 7;
   localparam int MAX_BUCKETS   = 64;
   localparam int SLOT_W        = $clog2(MAX_BUCKETS);
   localparam int VOL_W         = 25;
   localparam int HALF_W        = 26;
   localparam int TOTAL_W       = 31;
   localparam int FRACTION_BITS = 16;
   localparam int FRAC_W        = FRACTION_BITS + 1;
   localparam int ITER_W        = $clog2(FRACTION_BITS + 1);
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_BUCKET_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW      = 1'b1;

   localparam logic [BUCKET_W-1:0] BUCKET_RESET = 24'd50;
   localparam logic [WIN_W-1:0]    WIN_RESET    = 7'd50;

   typedef struct packed {
      logic [PRICE_W-1:0] trade_price;
      logic [QTY_W-1:0]   trade_quantity;
      logic [PRICE_W-1:0] reference_close;
   } req_payload_type;

   typedef struct packed {
      logic [FRAC_W-1:0] toxicity_fraction;
      logic              bucket_closed;
      logic [WIN_W-1:0]  buckets_held;
   } rsp_payload_type;

   typedef struct packed {
      logic             start;
      logic [VOL_W-1:0] imb;
      logic [VOL_W-1:0] vol;
   } win_cmd_type;

   typedef struct packed {
      logic               busy;
      logic [WIN_W-1:0]   count;
      logic [TOTAL_W-1:0] imb_total;
      logic [TOTAL_W-1:0] vol_total;
   } win_stat_type;

   typedef struct packed {
      logic               start;
      logic [TOTAL_W-1:0] num;
      logic [TOTAL_W-1:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic              busy;
      logic [FRAC_W-1:0] quotient;
   } div_stat_type;

endpackage

[rtl/vbe_req_if.sv]
// ----------------------------------------------------------------------------
// Trade channel
// Valid/ready channel that carries one trade per beat.
// ----------------------------------------------------------------------------
interface vbe_req_if;
   logic                     valid;
   logic                     ready;
   vbe_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/vbe_rsp_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one toxicity result per beat.
// ----------------------------------------------------------------------------
interface vbe_rsp_if;
   logic                     valid;
   logic                     ready;
   vbe_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/vbe_div.sv]
// ----------------------------------------------------------------------------
// Serial fraction divider
// Restoring divide of the window sums, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vbe_div (
   input  logic                  clock,
   input  logic                  reset,
   input  vbe_pkg::div_cmd_type  cmd,
   output vbe_pkg::div_stat_type stat
);

   logic                               busy_ff, busy_in;
   logic [vbe_pkg::ITER_W-1:0]         iter_ff, iter_in;
   logic [vbe_pkg::TOTAL_W-1:0]        rem_ff, rem_in;
   logic [vbe_pkg::TOTAL_W-1:0]        den_ff, den_in;
   logic [vbe_pkg::FRAC_W-1:0]         quo_ff, quo_in;
   logic [vbe_pkg::TOTAL_W:0]          rem_sh;
   logic                               take;

   assign rem_sh = {rem_ff, 1'b0};
   assign take   = (rem_sh >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      iter_in = iter_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         rem_in  = cmd.num;
         den_in  = cmd.den;
         quo_in  = '0;
         iter_in = vbe_pkg::ITER_W'(vbe_pkg::FRACTION_BITS);
         // An empty window answers zero; a full-imbalance window answers one.
         if (cmd.den == '0) begin
            iter_in = '0;
         end else if (cmd.num >= cmd.den) begin
            quo_in  = vbe_pkg::FRAC_W'(1) << vbe_pkg::FRACTION_BITS;
            iter_in = '0;
         end
      end else if (busy_ff) begin
         if (iter_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            iter_in = iter_ff - 1'b1;
            if (take) begin
               rem_in = vbe_pkg::TOTAL_W'(rem_sh - {1'b0, den_ff});
            end else begin
               rem_in = rem_sh[vbe_pkg::TOTAL_W-1:0];
            end
            quo_in = {quo_ff[vbe_pkg::FRAC_W-2:0], take};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign stat.busy     = busy_ff;
   assign stat.quotient = quo_ff;

endmodule

[rtl/vbe_window.sv]
// ----------------------------------------------------------------------------
// Bucket window
// Ring of closed buckets with running imbalance and volume sums.
// ----------------------------------------------------------------------------
module vbe_window (
   input  logic                       clock,
   input  logic                       reset,
   input  vbe_pkg::win_cmd_type       cmd,
   input  logic [vbe_pkg::WIN_W-1:0]  eff_win,
   output vbe_pkg::win_stat_type      stat
);

   localparam logic [1:0] W_IDLE  = 2'd0;
   localparam logic [1:0] W_EVICT = 2'd1;
   localparam logic [1:0] W_WRITE = 2'd2;

   localparam int WORD_W = 2 * vbe_pkg::VOL_W;

   logic [1:0]                    state_ff, state_in;
   logic [vbe_pkg::SLOT_W-1:0]    oldest_ff, oldest_in;
   logic [vbe_pkg::WIN_W-1:0]     count_ff, count_in;
   logic [vbe_pkg::TOTAL_W-1:0]   imb_total_ff, imb_total_in;
   logic [vbe_pkg::TOTAL_W-1:0]   vol_total_ff, vol_total_in;
   logic [vbe_pkg::VOL_W-1:0]     imb_ff, imb_in;
   logic [vbe_pkg::VOL_W-1:0]     vol_ff, vol_in;
   logic [WORD_W-1:0]             ring_mem_ff [vbe_pkg::MAX_BUCKETS];
   logic [WORD_W-1:0]             rd_word_ff;
   logic                          wr_en;
   logic [vbe_pkg::SLOT_W-1:0]    wr_slot;

   assign wr_slot = oldest_ff + count_ff[vbe_pkg::SLOT_W-1:0];
   assign wr_en   = (state_ff == W_WRITE);

   always_comb begin
      state_in     = state_ff;
      oldest_in    = oldest_ff;
      count_in     = count_ff;
      imb_total_in = imb_total_ff;
      vol_total_in = vol_total_ff;
      imb_in       = imb_ff;
      vol_in       = vol_ff;
      case (state_ff)
         W_IDLE: begin
            if (cmd.start) begin
               imb_in = cmd.imb;
               vol_in = cmd.vol;
               // The oldest entry is read every cycle, so it is ready next cycle.
               if (count_ff >= eff_win && count_ff != '0) begin
                  state_in = W_EVICT;
               end else begin
                  state_in = W_WRITE;
               end
            end
         end
         W_EVICT: begin
            imb_total_in = imb_total_ff
                         - vbe_pkg::TOTAL_W'(rd_word_ff[WORD_W-1:vbe_pkg::VOL_W]);
            vol_total_in = vol_total_ff
                         - vbe_pkg::TOTAL_W'(rd_word_ff[vbe_pkg::VOL_W-1:0]);
            oldest_in    = oldest_ff + 1'b1;
            count_in     = count_ff - 1'b1;
            state_in     = W_WRITE;
         end
         W_WRITE: begin
            imb_total_in = imb_total_ff + vbe_pkg::TOTAL_W'(imb_ff);
            vol_total_in = vol_total_ff + vbe_pkg::TOTAL_W'(vol_ff);
            count_in     = count_ff + 1'b1;
            state_in     = W_IDLE;
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= W_IDLE;
         oldest_ff    <= '0;
         count_ff     <= '0;
         imb_total_ff <= '0;
         vol_total_ff <= '0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         imb_total_ff <= imb_total_in;
         vol_total_ff <= vol_total_in;
      end
   end

   always_ff @(posedge clock) begin
      imb_ff <= imb_in;
      vol_ff <= vol_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem_ff[wr_slot] <= {imb_ff, vol_ff};
      end
      rd_word_ff <= ring_mem_ff[oldest_ff];
   end

   assign stat.busy      = (state_ff != W_IDLE);
   assign stat.count     = count_ff;
   assign stat.imb_total = imb_total_ff;
   assign stat.vol_total = vol_total_ff;

endmodule

[rtl/vpin_volume_bucket_estimator.sv]
// ----------------------------------------------------------------------------
// VPIN volume bucket estimator
// Sorts trade volume by tick rule into buckets and reports windowed toxicity.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  req_chan  in         trade_price, trade_quantity, reference_close
//  rsp_chan  out        toxicity_fraction, bucket_closed, buckets_held
//  csr_*     in         write enable, register index, write data
//
//  One trade is in flight at a time; a trade beat passes through the accumulate
//  state, the ring update when a bucket closes and the full 16-step divide. An
//  empty or zero-volume window, or one whose imbalance reaches its volume,
//  skips the divide. The result sits in an output register, so the next trade
//  is taken while it waits on ready.
//  Reset is synchronous and active high; the ring memory needs no clearing.
// ----------------------------------------------------------------------------
module vpin_volume_bucket_estimator (
   input  logic                            clock,
   input  logic                            reset,
   vbe_req_if.sink                         req_chan,
   vbe_rsp_if.source                       rsp_chan,
   input  logic                            csr_wen,
   input  logic [vbe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vbe_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ACC  = 2'd1;
   localparam logic [1:0] ST_PUSH = 2'd2;
   localparam logic [1:0] ST_DIV  = 2'd3;

   logic [1:0]                     state_ff, state_in;
   logic [vbe_pkg::BUCKET_W-1:0]   bucket_size_ff, bucket_size_in;
   logic [vbe_pkg::WIN_W-1:0]      window_ff, window_in;
   logic [vbe_pkg::VOL_W-1:0]      open_vol_ff, open_vol_in;
   logic [vbe_pkg::HALF_W-1:0]     open_half_ff, open_half_in;
   vbe_pkg::req_payload_type       trade_ff, trade_in;
   logic                           closed_ff, closed_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   vbe_pkg::rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic [vbe_pkg::WIN_W-1:0]      eff_win;
   logic [vbe_pkg::VOL_W-1:0]      sum_vol;
   logic [vbe_pkg::HALF_W-1:0]     sum_half;
   logic [vbe_pkg::HALF_W-1:0]     half_add;
   logic [vbe_pkg::HALF_W-1:0]     imb_wide;
   logic                           close_now;
   logic                           req_beat;

   vbe_pkg::win_cmd_type           win_cmd;
   vbe_pkg::win_stat_type          win_stat;
   vbe_pkg::div_cmd_type           div_cmd;
   vbe_pkg::div_stat_type          div_stat;

   vbe_window u_window (
      .clock   (clock),
      .reset   (reset),
      .cmd     (win_cmd),
      .eff_win (eff_win),
      .stat    (win_stat)
   );

   vbe_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   // Window register zero acts as one; anything above the ring depth is clamped.
   always_comb begin
      if (window_ff == '0) begin
         eff_win = vbe_pkg::WIN_W'(1);
      end else if (window_ff > vbe_pkg::WIN_W'(vbe_pkg::MAX_BUCKETS)) begin
         eff_win = vbe_pkg::WIN_W'(vbe_pkg::MAX_BUCKETS);
      end else begin
         eff_win = window_ff;
      end
   end

   assign req_beat = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // Tick rule: buys are counted in half shares, so an equal price adds half.
   always_comb begin
      if (trade_ff.trade_price > trade_ff.reference_close) begin
         half_add = {1'b0, trade_ff.trade_quantity, 1'b0};
      end else if (trade_ff.trade_price == trade_ff.reference_close) begin
         half_add = vbe_pkg::HALF_W'(trade_ff.trade_quantity);
      end else begin
         half_add = '0;
      end
   end

   assign sum_vol   = open_vol_ff + vbe_pkg::VOL_W'(trade_ff.trade_quantity);
   assign sum_half  = open_half_ff + half_add;
   assign close_now = (sum_vol >= vbe_pkg::VOL_W'(bucket_size_ff));
   assign imb_wide  = (sum_half >= vbe_pkg::HALF_W'(sum_vol))
                    ? (sum_half - vbe_pkg::HALF_W'(sum_vol))
                    : (vbe_pkg::HALF_W'(sum_vol) - sum_half);

   always_comb begin
      state_in       = state_ff;
      bucket_size_in = bucket_size_ff;
      window_in      = window_ff;
      open_vol_in    = open_vol_ff;
      open_half_in   = open_half_ff;
      trade_in       = trade_ff;
      closed_in      = closed_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      win_cmd.start  = 1'b0;
      win_cmd.imb    = vbe_pkg::VOL_W'(imb_wide);
      win_cmd.vol    = sum_vol;
      div_cmd.start  = 1'b0;
      div_cmd.num    = win_stat.imb_total;
      div_cmd.den    = win_stat.vol_total;

      if (csr_wen) begin
         case (csr_index)
            vbe_pkg::CSR_BUCKET_SIZE: bucket_size_in = csr_wdata;
            vbe_pkg::CSR_WINDOW:      window_in = csr_wdata[vbe_pkg::WIN_W-1:0];
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               trade_in = req_chan.payload;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            closed_in = close_now;
            if (close_now) begin
               win_cmd.start = 1'b1;
               open_vol_in   = '0;
               open_half_in  = '0;
               state_in      = ST_PUSH;
            end else begin
               open_vol_in   = sum_vol;
               open_half_in  = sum_half;
               div_cmd.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_PUSH: begin
            if (!win_stat.busy) begin
               div_cmd.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!div_stat.busy && (!rsp_valid_ff || rsp_chan.ready)) begin
               rsp_valid_in                  = 1'b1;
               rsp_data_in.toxicity_fraction = div_stat.quotient;
               rsp_data_in.bucket_closed     = closed_ff;
               rsp_data_in.buckets_held      = win_stat.count;
               state_in                      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         bucket_size_ff <= vbe_pkg::BUCKET_RESET;
         window_ff      <= vbe_pkg::WIN_RESET;
         open_vol_ff    <= '0;
         open_half_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         bucket_size_ff <= bucket_size_in;
         window_ff      <= window_in;
         open_vol_ff    <= open_vol_in;
         open_half_ff   <= open_half_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      trade_ff    <= trade_in;
      closed_ff   <= closed_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // Each bucket's imbalance never exceeds its volume, so neither do the sums.
   a_totals_ordered : assert property (@(posedge clock) disable iff (reset)
      win_stat.imb_total <= win_stat.vol_total)
      else $error("window imbalance sum exceeds volume sum");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      win_stat.count <= vbe_pkg::WIN_W'(vbe_pkg::MAX_BUCKETS))
      else $error("ring holds more buckets than it has slots");

   a_window_busy_push : assert property (@(posedge clock) disable iff (reset)
      win_stat.busy |-> state_ff == ST_PUSH)
      else $error("ring update running outside the push phase");

   a_fraction_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.toxicity_fraction
                       <= (vbe_pkg::FRAC_W'(1) << vbe_pkg::FRACTION_BITS))
      else $error("toxicity fraction above one");

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// VPIN volume bucket estimator testbench
// Sends trades through the request channel and holds its own model of the
// bucket ring, the running sums and the toxicity divide. Every result beat is
// checked against the next predicted result. A short directed script covers
// the register and bucket edge cases, then random trades run under several
// register settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;

   localparam int PHASE_COUNT      = 6;
   localparam int TRADES_PER_PHASE = 300;
   localparam int DRAIN_LIMIT      = 20000;
   localparam int SETTLE_CYCLES    = 30;
   localparam int REPORT_LIMIT     = 10;

   typedef enum logic {ROW_TRADE, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type                      kind;
      logic [vbe_pkg::CSR_IDX_W-1:0]     reg_index;
      logic [vbe_pkg::CSR_DATA_W-1:0]    reg_value;
      vbe_pkg::req_payload_type          trade;
      bit                                known;
      vbe_pkg::rsp_payload_type          result;
   } script_row_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_wen;
   logic [vbe_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [vbe_pkg::CSR_DATA_W-1:0] csr_wdata;

   vbe_req_if req_if ();
   vbe_rsp_if rsp_if ();

   // Register settings and bucket state as the block should hold them.
   logic [vbe_pkg::BUCKET_W-1:0] bucket_size_setting;
   logic [vbe_pkg::WIN_W-1:0]    window_setting;
   logic [vbe_pkg::VOL_W-1:0]    open_volume;
   logic [vbe_pkg::HALF_W-1:0]   open_buy_halves;
   logic [vbe_pkg::VOL_W-1:0]    imbalance_slots [vbe_pkg::MAX_BUCKETS];
   logic [vbe_pkg::VOL_W-1:0]    volume_slots [vbe_pkg::MAX_BUCKETS];
   logic [vbe_pkg::SLOT_W-1:0]   oldest_slot;
   logic [vbe_pkg::WIN_W-1:0]    held_count;
   logic [vbe_pkg::TOTAL_W-1:0]  imbalance_sum;
   logic [vbe_pkg::TOTAL_W-1:0]  volume_sum;

   vbe_pkg::rsp_payload_type pending_scores [$];
   script_row_type           script [$];
   int unsigned              fault_count;
   int unsigned              send_idle_pct;
   int unsigned              recv_idle_pct;

   vpin_volume_bucket_estimator dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic vbe_pkg::rsp_payload_type score_trade(vbe_pkg::req_payload_type t);
      vbe_pkg::rsp_payload_type                           r;
      logic [vbe_pkg::VOL_W-1:0]                          imb;
      logic [vbe_pkg::WIN_W-1:0]                          span;
      logic [vbe_pkg::SLOT_W-1:0]                         slot;
      logic [vbe_pkg::TOTAL_W+vbe_pkg::FRACTION_BITS-1:0] numer;
      r = '0;
      if (t.trade_price > t.reference_close) begin
         open_buy_halves = open_buy_halves + {t.trade_quantity, 1'b0};
      end else if (t.trade_price == t.reference_close) begin
         open_buy_halves = open_buy_halves + t.trade_quantity;
      end
      open_volume = open_volume + t.trade_quantity;
      if (open_volume >= bucket_size_setting) begin
         imb = (open_buy_halves >= open_volume)
             ? vbe_pkg::VOL_W'(open_buy_halves - open_volume)
             : vbe_pkg::VOL_W'(open_volume - open_buy_halves);
         span = (window_setting == '0) ? vbe_pkg::WIN_W'(1) :
                (window_setting > vbe_pkg::WIN_W'(vbe_pkg::MAX_BUCKETS))
                ? vbe_pkg::WIN_W'(vbe_pkg::MAX_BUCKETS) : window_setting;
         // After the window is lowered the ring stays over-full: one bucket
         // leaves for each one that enters, so the count never drops.
         if (held_count >= span && held_count != '0) begin
            imbalance_sum = imbalance_sum - imbalance_slots[oldest_slot];
            volume_sum    = volume_sum - volume_slots[oldest_slot];
            oldest_slot   = oldest_slot + 1'b1;
            held_count    = held_count - 1'b1;
         end
         slot = oldest_slot + vbe_pkg::SLOT_W'(held_count);
         imbalance_slots[slot] = imb;
         volume_slots[slot]    = open_volume;
         imbalance_sum   = imbalance_sum + imb;
         volume_sum      = volume_sum + open_volume;
         held_count      = held_count + 1'b1;
         open_volume     = '0;
         open_buy_halves = '0;
         r.bucket_closed = 1'b1;
      end
      if (held_count == '0 || volume_sum == '0) begin
         r.toxicity_fraction = '0;
      end else if (imbalance_sum >= volume_sum) begin
         r.toxicity_fraction = vbe_pkg::FRAC_W'(1) << vbe_pkg::FRACTION_BITS;
      end else begin
         numer = {imbalance_sum, {vbe_pkg::FRACTION_BITS{1'b0}}};
         r.toxicity_fraction = vbe_pkg::FRAC_W'(numer / volume_sum);
      end
      r.buckets_held = held_count;
      return r;
   endfunction

   function automatic vbe_pkg::req_payload_type random_trade();
      vbe_pkg::req_payload_type t;
      int unsigned              qty_span;
      int unsigned              draw;
      t.trade_price = $urandom;
      draw = $urandom_range(0, 2);
      if (draw == 0) begin
         t.reference_close = t.trade_price;
      end else if (draw == 1) begin
         t.reference_close = $urandom;
      end else begin
         t.reference_close = t.trade_price ^ (32'd1 << $urandom_range(0, 31));
      end
      // Most quantities are sized so that a bucket closes every few trades.
      qty_span = bucket_size_setting / 2 + 1;
      draw = $urandom_range(0, 9);
      if (draw == 0) begin
         t.trade_quantity = '0;
      end else if (draw == 1) begin
         t.trade_quantity = vbe_pkg::QTY_W'($urandom);
      end else begin
         t.trade_quantity = vbe_pkg::QTY_W'($urandom_range(0, qty_span));
      end
      return t;
   endfunction

   function automatic void queue_trade(logic [vbe_pkg::PRICE_W-1:0] price,
                                       logic [vbe_pkg::QTY_W-1:0] qty,
                                       logic [vbe_pkg::PRICE_W-1:0] close_price);
      script_row_type row;
      row.kind      = ROW_TRADE;
      row.reg_index = '0;
      row.reg_value = '0;
      row.trade     = '{price, qty, close_price};
      row.known     = 1'b0;
      row.result    = '0;
      script.insert(script.size(), row);
   endfunction

   function automatic void add_known(logic [vbe_pkg::PRICE_W-1:0] price,
                                     logic [vbe_pkg::QTY_W-1:0] qty,
                                     logic [vbe_pkg::PRICE_W-1:0] close_price,
                                     logic [vbe_pkg::FRAC_W-1:0] frac,
                                     logic closed, logic [vbe_pkg::WIN_W-1:0] held);
      queue_trade(price, qty, close_price);
      script[$].known  = 1'b1;
      script[$].result = '{frac, closed, held};
   endfunction

   function automatic void add_write(logic [vbe_pkg::CSR_IDX_W-1:0] index,
                                     logic [vbe_pkg::CSR_DATA_W-1:0] value);
      script_row_type row;
      row.kind      = ROW_WRITE;
      row.reg_index = index;
      row.reg_value = value;
      row.trade     = '0;
      row.known     = 1'b0;
      row.result    = '0;
      script.insert(script.size(), row);
   endfunction

   function automatic void build_script();
      // Reset settings: bucket size 50, window 50.
      add_known(32'd0, 24'd0, 32'd0, 17'd0, 1'b0, 7'd0);
      add_known(32'hFFFF_FFFF, 24'd50, 32'd0, 17'd65536, 1'b1, 7'd1);
      add_known(32'd0, 24'hFF_FFFF, 32'hFFFF_FFFF, 17'd65536, 1'b1, 7'd2);
      queue_trade(32'd1000, 24'd60, 32'd1000);
      queue_trade(32'd5, 24'd20, 32'd9);
      queue_trade(32'd9, 24'd30, 32'd5);
      // Window lowered below the buckets already held.
      add_write(vbe_pkg::CSR_WINDOW, 24'd1);
      queue_trade(32'd7, 24'd50, 32'd7);
      add_write(vbe_pkg::CSR_WINDOW, 24'd0);
      queue_trade(32'd8, 24'd55, 32'd3);
      add_write(vbe_pkg::CSR_WINDOW, 24'd127);
      // Zero bucket size: every trade closes a bucket, even an empty one. Four
      // empty buckets flush the ring, which leaves zero total volume.
      add_write(vbe_pkg::CSR_BUCKET_SIZE, 24'd0);
      add_write(vbe_pkg::CSR_WINDOW, 24'd3);
      queue_trade(32'd6, 24'd0, 32'd2);
      queue_trade(32'd2, 24'd0, 32'd6);
      queue_trade(32'd4, 24'd0, 32'd4);
      add_known(32'd4, 24'd0, 32'd4, 17'd0, 1'b1, 7'd4);
      // Bucket size dropped under the open volume closes on the next trade.
      add_write(vbe_pkg::CSR_BUCKET_SIZE, 24'd100);
      add_known(32'd1, 24'd40, 32'd2, 17'd0, 1'b0, 7'd4);
      add_write(vbe_pkg::CSR_BUCKET_SIZE, 24'd10);
      add_known(32'd3, 24'd0, 32'd3, 17'd65536, 1'b1, 7'd4);
      add_write(vbe_pkg::CSR_BUCKET_SIZE, 24'hFF_FFFF);
      add_write(vbe_pkg::CSR_WINDOW, 24'd64);
      add_known(32'd2, 24'hFF_FFFF, 32'd1, 17'd65536, 1'b1, 7'd5);
      add_write(vbe_pkg::CSR_BUCKET_SIZE, 24'd1);
      add_known(32'd4, 24'd1, 32'd4, 17'd65535, 1'b1, 7'd6);
      queue_trade(32'd1, 24'd3, 32'd0);
      queue_trade(32'd4, 24'd2, 32'd4);
   endfunction

   task automatic offer_trade(vbe_pkg::req_payload_type t, bit known,
                              vbe_pkg::rsp_payload_type typed);
      vbe_pkg::rsp_payload_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= t;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = score_trade(t);
      pending_scores.insert(pending_scores.size(), known ? typed : predicted);
   endtask

   task automatic write_register(logic [vbe_pkg::CSR_IDX_W-1:0] index,
                                 logic [vbe_pkg::CSR_DATA_W-1:0] value);
      req_if.valid <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (index == vbe_pkg::CSR_BUCKET_SIZE) begin
         bucket_size_setting = value[vbe_pkg::BUCKET_W-1:0];
      end else begin
         window_setting = value[vbe_pkg::WIN_W-1:0];
      end
      @(posedge clock);
   endtask

   // Result side: random backpressure and the check of each result beat.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      vbe_pkg::rsp_payload_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_scores.size() == 0) begin
            if (fault_count < REPORT_LIMIT) begin
               $display("unexpected result beat: fraction %0d closed %0d held %0d",
                        rsp_if.payload.toxicity_fraction, rsp_if.payload.bucket_closed,
                        rsp_if.payload.buckets_held);
            end
            fault_count++;
         end else begin
            want = pending_scores[0];
            pending_scores.delete(0);
            if (rsp_if.payload.toxicity_fraction !== want.toxicity_fraction ||
                rsp_if.payload.bucket_closed !== want.bucket_closed ||
                rsp_if.payload.buckets_held !== want.buckets_held) begin
               if (fault_count < REPORT_LIMIT) begin
                  $display("mismatch: fraction %0d/%0d closed %0d/%0d held %0d/%0d (exp/got)",
                           want.toxicity_fraction, rsp_if.payload.toxicity_fraction,
                           want.bucket_closed, rsp_if.payload.bucket_closed,
                           want.buckets_held, rsp_if.payload.buckets_held);
               end
               fault_count++;
            end
         end
      end
   end

   initial begin
      int unsigned drain;
      reset          <= 1'b1;
      csr_wen        <= 1'b0;
      csr_index      <= vbe_pkg::CSR_BUCKET_SIZE;
      csr_wdata      <= '0;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      fault_count         = 0;
      bucket_size_setting = vbe_pkg::BUCKET_RESET;
      window_setting      = vbe_pkg::WIN_RESET;
      open_volume         = '0;
      open_buy_halves     = '0;
      oldest_slot         = '0;
      held_count          = '0;
      imbalance_sum       = '0;
      volume_sum          = '0;
      send_idle_pct       = 28;
      recv_idle_pct       = 50;
      build_script();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_WRITE) begin
            write_register(script[i].reg_index, script[i].reg_value);
         end else begin
            offer_trade(script[i].trade, script[i].known, script[i].result);
         end
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               write_register(vbe_pkg::CSR_BUCKET_SIZE, 24'd50);
               write_register(vbe_pkg::CSR_WINDOW, 24'd50);
            end
            1: begin
               write_register(vbe_pkg::CSR_BUCKET_SIZE, 24'd1);
               write_register(vbe_pkg::CSR_WINDOW, 24'd64);
            end
            2: begin
               send_idle_pct = 50;
               recv_idle_pct = 28;
               write_register(vbe_pkg::CSR_BUCKET_SIZE, 24'hFF_FFFF);
               write_register(vbe_pkg::CSR_WINDOW, 24'd1);
            end
            3: begin
               write_register(vbe_pkg::CSR_BUCKET_SIZE,
                              vbe_pkg::CSR_DATA_W'($urandom_range(2, 5000)));
               write_register(vbe_pkg::CSR_WINDOW,
                              vbe_pkg::CSR_DATA_W'($urandom_range(1, 64)));
            end
            4: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               write_register(vbe_pkg::CSR_BUCKET_SIZE, 24'd0);
               write_register(vbe_pkg::CSR_WINDOW, 24'd127);
            end
            default: begin
               write_register(vbe_pkg::CSR_BUCKET_SIZE, vbe_pkg::CSR_DATA_W'($urandom));
               write_register(vbe_pkg::CSR_WINDOW,
                              vbe_pkg::CSR_DATA_W'($urandom_range(0, 127)));
            end
         endcase
         repeat (TRADES_PER_PHASE) offer_trade(random_trade(), 1'b0, '0);
      end
      req_if.valid <= 1'b0;

      drain = 0;
      while (pending_scores.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending_scores.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[files.f]
rtl/vbe_pkg.sv
rtl/vbe_req_if.sv
rtl/vbe_rsp_if.sv
rtl/vbe_div.sv
rtl/vbe_window.sv
rtl/vpin_volume_bucket_estimator.sv
verif/testbench.sv
